// ===== hw/rtl/bmhq_pkg.sv =====
// Package for the binary min-heap queue: sizes, entry layout, datapath
// operation codes, status bundle and controller states. No dependencies.
package bmhq_pkg;

  // Heap capacity and the widths that follow from it.
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = IDX_W + 1;
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ENTRY_W  = PRIO_W + DATA_W;

  // Command codes on cmd_i.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  // One heap entry as stored in the RAM.
  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic        [DATA_W-1:0] data;
  } entry_t;

  // Operations the controller asks of the datapath, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INS_START,
    OP_INS_FULL,
    OP_POP_START,
    OP_POP_EMPTY,
    OP_PLACE,
    OP_RD_PAR,
    OP_UP_STEP,
    OP_RD_LAST,
    OP_LD_X,
    OP_RD_LC,
    OP_RD_RC,
    OP_DN_STEP
  } dp_op_e;

  // Status the datapath reports back to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic lc_in;
    logic up_move;
    logic dn_move;
  } dp_status_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_LAST,
    ST_DN_LDX,
    ST_DN_L,
    ST_DN_R,
    ST_DN_CMP,
    ST_DONE
  } ctl_state_e;

endpackage

// ===== hw/rtl/bmhq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependencies.
module bmhq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bmhq_dp.sv =====
// Datapath of the heap queue: entry store, moving entry, sift position,
// fill count, cached root and result registers. Uses bmhq_pkg and bmhq_ram.
module bmhq_dp
  import bmhq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_op_e                   op_i,
  input  logic signed [PRIO_W-1:0] item_priority_i,
  input  logic signed [DATA_W-1:0] item_data_i,
  output dp_status_t               status_o,
  output logic signed [PRIO_W-1:0] popped_priority_o,
  output logic signed [DATA_W-1:0] popped_data_o,
  output logic                     pop_ok_o,
  output logic                     overflow_o,
  output logic [CNT_W-1:0]         entry_count_o,
  output logic signed [PRIO_W-1:0] top_priority_o,
  output logic signed [DATA_W-1:0] top_data_o
);

  // Registers.
  logic [CNT_W-1:0] count_q, count_d;
  logic             pop_ok_q, pop_ok_d;
  logic             ovf_q, ovf_d;
  entry_t           x_q, x_d;
  entry_t           l_q, l_d;
  entry_t           root_q, root_d;
  entry_t           popped_q, popped_d;
  logic [IDX_W-1:0] pos_q, pos_d;

  // RAM port signals.
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  entry_t           wdata;
  logic [ENTRY_W-1:0] rdata_raw;
  entry_t           rd;

  // Neighbor indexes and comparisons.
  logic [IDX_W+1:0] lc_w;
  logic [IDX_W+1:0] rc_w;
  logic [IDX_W+1:0] count_w;
  logic [IDX_W-1:0] par;
  logic             lc_in;
  logic             rc_in;
  logic             up_move;
  logic             l_less;
  logic             r_less;
  entry_t           best_l;
  entry_t           best;
  logic [IDX_W-1:0] best_idx;

  bmhq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  assign rd = entry_t'(rdata_raw);

  // Children and parent of the current position.
  assign lc_w    = {1'b0, pos_q, 1'b1};
  assign rc_w    = lc_w + 1'b1;
  assign count_w = {1'b0, count_q};
  assign par     = IDX_W'((pos_q - 1'b1) >> 1);
  assign lc_in   = lc_w < count_w;
  assign rc_in   = rc_w < count_w;

  // Sift-up test: the moving entry is strictly smaller than its parent.
  assign up_move = $signed(x_q.prio) < $signed(rd.prio);

  // Sift-down selection: left child first, right child only if smaller still.
  assign l_less   = lc_in && ($signed(l_q.prio) < $signed(x_q.prio));
  assign best_l   = l_less ? l_q : x_q;
  assign r_less   = rc_in && ($signed(rd.prio) < $signed(best_l.prio));
  assign best     = r_less ? rd : l_q;
  assign best_idx = r_less ? rc_w[IDX_W-1:0] : lc_w[IDX_W-1:0];

  // Status back to the controller.
  assign status_o.full     = count_q == CNT_W'(CAPACITY);
  assign status_o.empty    = count_q == '0;
  assign status_o.pos_zero = pos_q == '0;
  assign status_o.lc_in    = lc_in;
  assign status_o.up_move  = up_move;
  assign status_o.dn_move  = l_less || r_less;

  // RAM addressing and writes for each operation.
  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = pos_q;
    wdata = x_q;
    unique case (op_i)
      OP_RD_PAR:  raddr = par;
      OP_RD_LAST: raddr = count_q[IDX_W-1:0];
      OP_RD_LC:   raddr = lc_w[IDX_W-1:0];
      OP_RD_RC:   raddr = rc_w[IDX_W-1:0];
      OP_PLACE:   we = 1'b1;
      OP_UP_STEP: begin
        we    = 1'b1;
        wdata = up_move ? rd : x_q;
      end
      OP_DN_STEP: begin
        we    = 1'b1;
        wdata = (l_less || r_less) ? best : x_q;
      end
      default: ;
    endcase
  end

  // Next register values.
  always_comb begin
    count_d  = count_q;
    pop_ok_d = pop_ok_q;
    ovf_d    = ovf_q;
    x_d      = x_q;
    l_d      = l_q;
    pos_d    = pos_q;
    popped_d = popped_q;
    root_d   = (we && waddr == '0) ? wdata : root_q;
    unique case (op_i)
      OP_INS_START: begin
        x_d.prio = item_priority_i;
        x_d.data = item_data_i;
        pos_d    = count_q[IDX_W-1:0];
        count_d  = count_q + 1'b1;
        pop_ok_d = 1'b0;
        ovf_d    = 1'b0;
        popped_d = '0;
      end
      OP_INS_FULL: begin
        pop_ok_d = 1'b0;
        ovf_d    = 1'b1;
        popped_d = '0;
      end
      OP_POP_START: begin
        popped_d = root_q;
        pop_ok_d = 1'b1;
        ovf_d    = 1'b0;
        count_d  = count_q - 1'b1;
      end
      OP_POP_EMPTY: begin
        pop_ok_d = 1'b0;
        ovf_d    = 1'b0;
        popped_d = '0;
      end
      OP_LD_X: begin
        x_d   = rd;
        pos_d = '0;
      end
      OP_RD_RC: l_d = rd;
      OP_UP_STEP: begin
        if (up_move) begin
          pos_d = par;
        end
      end
      OP_DN_STEP: begin
        if (l_less || r_less) begin
          pos_d = best_idx;
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      pop_ok_q <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      count_q  <= count_d;
      pop_ok_q <= pop_ok_d;
      ovf_q    <= ovf_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    l_q      <= l_d;
    pos_q    <= pos_d;
    root_q   <= root_d;
    popped_q <= popped_d;
  end

  // Result outputs; the root reads as zero when the heap is empty.
  assign popped_priority_o = popped_q.prio;
  assign popped_data_o     = popped_q.data;
  assign pop_ok_o          = pop_ok_q;
  assign overflow_o        = ovf_q;
  assign entry_count_o     = count_q;
  assign top_priority_o    = (count_q != '0) ? root_q.prio : '0;
  assign top_data_o        = (count_q != '0) ? root_q.data : '0;

`ifndef NO_ASSERTIONS
  // An accepted insert grows the count by one.
  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_INS_START |=> count_q == CNT_W'($past(count_q) + 1'b1))
    else $error("insert did not grow the entry count");

  // A pop of a nonempty heap shrinks the count and reports success.
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_POP_START |=> pop_ok_q && count_q == CNT_W'($past(count_q) - 1'b1))
    else $error("pop did not shrink the entry count");

  // Sifting only writes inside the occupied part of the heap.
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> {1'b0, waddr} < count_q)
    else $error("heap write beyond the fill count");

  // A step never reports both a pop and an overflow.
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_ok_q && ovf_q))
    else $error("pop_ok and overflow set together");
`endif

endmodule

// ===== hw/rtl/bmhq_ctrl.sv =====
// Controller of the heap queue: sequences insert and pop through the sift
// steps of the datapath. Uses bmhq_pkg.
module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       cmd_i,
  input  dp_status_t status_i,
  output dp_op_e     op_o,
  output logic       busy,
  output logic       done_o
);

  ctl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath operation.
  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (cmd_i == CMD_INSERT) begin
            if (status_i.full) begin
              op_o    = OP_INS_FULL;
              state_d = ST_DONE;
            end else begin
              op_o    = OP_INS_START;
              state_d = ST_UP_RD;
            end
          end else begin
            if (status_i.empty) begin
              op_o    = OP_POP_EMPTY;
              state_d = ST_DONE;
            end else begin
              op_o    = OP_POP_START;
              state_d = ST_DN_LAST;
            end
          end
        end
      end
      // Sift up: read the parent, or settle at the root.
      ST_UP_RD: begin
        if (status_i.pos_zero) begin
          op_o    = OP_PLACE;
          state_d = ST_DONE;
        end else begin
          op_o    = OP_RD_PAR;
          state_d = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        op_o    = OP_UP_STEP;
        state_d = status_i.up_move ? ST_UP_RD : ST_DONE;
      end
      // Pop: fetch the last entry unless the heap is now empty.
      ST_DN_LAST: begin
        if (status_i.empty) begin
          state_d = ST_DONE;
        end else begin
          op_o    = OP_RD_LAST;
          state_d = ST_DN_LDX;
        end
      end
      ST_DN_LDX: begin
        op_o    = OP_LD_X;
        state_d = ST_DN_L;
      end
      // Sift down: read both children, then compare and move, or place the entry at a node without children.
      ST_DN_L: begin
        if (status_i.lc_in) begin
          op_o    = OP_RD_LC;
          state_d = ST_DN_R;
        end else begin
          op_o    = OP_PLACE;
          state_d = ST_DONE;
        end
      end
      ST_DN_R: begin
        op_o    = OP_RD_RC;
        state_d = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        op_o    = OP_DN_STEP;
        state_d = status_i.dn_move ? ST_DN_L : ST_DONE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy   = state_q != ST_IDLE;
  assign done_o = state_q == ST_DONE;

endmodule

// ===== hw/rtl/binary_min_heap_queue_top.sv =====
// Top level of the binary min-heap priority queue.
// Uses bmhq_pkg, bmhq_ctrl and bmhq_dp.
//
//   Channel   Handshake          Ports
//   command   start && !busy     cmd_i, item_priority_i, item_data_i
//   result    done_o (1 cycle)   popped_*_o, pop_ok_o, overflow_o,
//                                entry_count_o, top_*_o
//
// One beat is worked on at a time. An insert strobes its result once the new
// entry has risen as far as it goes, to the root or below a parent that is
// not larger; a pop once the moved entry has sunk to a node without children
// or with no smaller child, or at once if the pop left the heap empty. The
// single RAM read port is registered and sets the step length. Reset empties
// the heap at once with no sweep; the receiver cannot stall, and busy stays
// high through the result cycle.
module binary_min_heap_queue_top
  import bmhq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     cmd_i,
  input  logic signed [PRIO_W-1:0] item_priority_i,
  input  logic signed [DATA_W-1:0] item_data_i,
  output logic                     done_o,
  output logic signed [PRIO_W-1:0] popped_priority_o,
  output logic signed [DATA_W-1:0] popped_data_o,
  output logic                     pop_ok_o,
  output logic                     overflow_o,
  output logic [CNT_W-1:0]         entry_count_o,
  output logic signed [PRIO_W-1:0] top_priority_o,
  output logic signed [DATA_W-1:0] top_data_o
);

  dp_op_e     op;
  dp_status_t status;

  // Sequencer.
  bmhq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .cmd_i   (cmd_i),
    .status_i(status),
    .op_o    (op),
    .busy    (busy),
    .done_o  (done_o)
  );

  // Heap storage and sift datapath.
  bmhq_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op),
    .item_priority_i  (item_priority_i),
    .item_data_i      (item_data_i),
    .status_o         (status),
    .popped_priority_o(popped_priority_o),
    .popped_data_o    (popped_data_o),
    .pop_ok_o         (pop_ok_o),
    .overflow_o       (overflow_o),
    .entry_count_o    (entry_count_o),
    .top_priority_o   (top_priority_o),
    .top_data_o       (top_data_o)
  );

endmodule
